### hw/rtl/dmth_pkg.sv
// Shared constants, item types and arithmetic helpers for the decimal multilane text hash.
package dmth_pkg;

	localparam int LANES     = 4;
	localparam int ACC_W     = 54;
	localparam int PROD_W    = ACC_W + 4;
	localparam int POS_W     = 17;
	localparam int IV_W      = 15;
	localparam int DIG_W     = 64;
	localparam int NUM_OUT   = 8 * LANES;
	localparam int EIDX_W    = $clog2(NUM_OUT);
	localparam int LIDX_W    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int BIT_W     = $clog2(ACC_W);
	localparam int Q_DEPTH   = 2;
	localparam int QPTR_W    = $clog2(Q_DEPTH);
	localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [ACC_W-1:0] MOD16    = 54'd10000000000000000;
	localparam logic [ACC_W-1:0] MIN16    = 54'd1000000000000000;
	localparam logic [ACC_W-1:0] SEED     = 54'd5555555555555555;
	localparam logic [POS_W-1:0] POS_MAX  = 17'd131071;
	localparam logic [IV_W-1:0]  IV_RESET = 15'd10000;
	localparam logic [6:0]       CHAR_BIAS = 7'd32;
	localparam logic [6:0]       NUM_MOD   = 7'd100;
	localparam logic [6:0]       NUM_WRAP  = 7'd94;

	// Register byte address of the snapshot interval.
	localparam logic [ADDR_W-1:0] REG_INTERVAL = 3'd0;

	typedef struct packed {
		logic [6:0] character;
		logic       last_input;
	} in_item_t;

	typedef struct packed {
		logic [6:0] digest_char;
		logic       last_char;
	} out_item_t;

	typedef logic [LANES-1:0][ACC_W-1:0] lane_vec_t;

	// Final lane state of one message, handed from front to back.
	typedef struct packed {
		lane_vec_t acc;
		lane_vec_t snap;
	} rec_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_FOLD,
		BK_EMIT
	} back_state_t;

	// (a + b) mod 10^16 for a, b below 10^16.
	function automatic logic [ACC_W-1:0] add_mod(input logic [ACC_W-1:0] a,
	                                             input logic [ACC_W-1:0] b);
		logic [ACC_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= {1'b0, MOD16}) begin
			t = t - {1'b0, MOD16};
		end
		return t[ACC_W-1:0];
	endfunction

	// One lane update: ((acc + ch - 32) mod 10^16) * mul mod 10^16.
	function automatic logic [ACC_W-1:0] lane_step(input logic [ACC_W-1:0] acc,
	                                               input logic [6:0] ch,
	                                               input logic [3:0] mul);
		logic [ACC_W:0]  t;
		logic [6:0]      dv;
		logic [PROD_W-1:0] p;
		logic [PROD_W-1:0] r;
		if (ch >= CHAR_BIAS) begin
			dv = ch - CHAR_BIAS;
			t = {1'b0, acc} + (ACC_W+1)'(dv);
		end else begin
			dv = CHAR_BIAS - ch;
			t = {1'b0, acc} + {1'b0, MOD16} - (ACC_W+1)'(dv);
		end
		if (t >= {1'b0, MOD16}) begin
			t = t - {1'b0, MOD16};
		end
		p = PROD_W'(t[ACC_W-1:0]) * PROD_W'(mul);
		r = p;
		// The product is below 9 * 10^16; strip whole multiples of the modulus.
		for (int j = 1; j <= 8; j++) begin
			if (p >= PROD_W'(j) * PROD_W'(MOD16)) begin
				r = p - PROD_W'(j) * PROD_W'(MOD16);
			end
		end
		return r[ACC_W-1:0];
	endfunction

	// Double-dabble correction: every BCD digit of 5 or more gains 3.
	function automatic logic [DIG_W-1:0] bcd_adj(input logic [DIG_W-1:0] d);
		logic [DIG_W-1:0] r;
		r = d;
		for (int i = 0; i < DIG_W / 4; i++) begin
			if (d[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = d[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	// Two BCD digits to a binary number below 100.
	function automatic logic [6:0] pair_bin(input logic [7:0] p);
		return 7'({p[7:4], 3'b000}) + 7'({p[7:4], 1'b0}) + 7'(p[3:0]);
	endfunction

	// (a + b) mod 100 for a, b below 100.
	function automatic logic [6:0] add_mod100(input logic [6:0] a, input logic [6:0] b);
		logic [7:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, NUM_MOD}) begin
			s = s - {1'b0, NUM_MOD};
		end
		return s[6:0];
	endfunction

endpackage

### hw/rtl/dmth_front.sv
// Front part: accepts characters and folds them into the lane accumulators and snapshot sums.
module dmth_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_stall,
	input  dmth_pkg::in_item_t        char_item,
	input  logic [dmth_pkg::IV_W-1:0] interval,
	input  logic                      q_full,
	output logic                      push,
	output dmth_pkg::rec_t            push_rec
);
	import dmth_pkg::*;

	lane_vec_t        acc_q;
	lane_vec_t        snap_q;
	logic [POS_W-1:0] pos_q;
	lane_vec_t        acc_nx;
	lane_vec_t        snap_nx;
	logic [POS_W-1:0] iv1;
	logic [POS_W-1:0] iv2;
	logic [POS_W-1:0] iv3;
	logic [POS_W-1:0] iv4;
	logic             snap_hit;
	logic             accept;

	// A full queue holds back the next item.
	assign char_stall = q_full;
	assign accept     = char_valid & ~q_full;

	// Snapshot positions are the first four multiples of the interval.
	assign iv1 = POS_W'(interval);
	assign iv2 = iv1 << 1;
	assign iv3 = iv2 + iv1;
	assign iv4 = iv1 << 2;
	assign snap_hit = (pos_q == iv1) || (pos_q == iv2) || (pos_q == iv3) || (pos_q == iv4);

	// Lane k multiplies by k + 2.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			acc_nx[k]  = lane_step(acc_q[k], char_item.character, 4'(k + 2));
			snap_nx[k] = snap_hit ? add_mod(snap_q[k], acc_nx[k]) : snap_q[k];
		end
	end

	// The last character hands the finished lane state to the back part.
	assign push          = accept & char_item.last_input;
	assign push_rec.acc  = acc_nx;
	assign push_rec.snap = snap_nx;

	// Lane state, cleared again after each message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANES; k++) begin
				acc_q[k]  <= SEED;
				snap_q[k] <= SEED;
			end
			pos_q <= '0;
		end else if (accept) begin
			if (char_item.last_input) begin
				for (int k = 0; k < LANES; k++) begin
					acc_q[k]  <= SEED;
					snap_q[k] <= SEED;
				end
				pos_q <= '0;
			end else begin
				acc_q  <= acc_nx;
				snap_q <= snap_nx;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/dmth_queue.sv
// Short queue of finished message records between the front and back parts.
module dmth_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dmth_pkg::rec_t push_rec,
	output logic           full,
	output logic           nonempty,
	input  logic           pop,
	output dmth_pkg::rec_t head
);
	import dmth_pkg::*;

	rec_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/dmth_back.sv
// Back part: turns one message record into its digest and emits it one character per item.
module dmth_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_nonempty,
	input  dmth_pkg::rec_t       head,
	output logic                 pop,
	output logic                 dig_valid,
	input  logic                 dig_stall,
	output dmth_pkg::out_item_t  dig_item
);
	import dmth_pkg::*;

	back_state_t              state_q;
	back_state_t              state_nx;
	lane_vec_t                dbin_q;
	lane_vec_t                sbin_q;
	logic [LANES*DIG_W-1:0]   digits_q;
	logic [7:0]               sbcd_q [LANES];
	logic [BIT_W-1:0]         bit_q;
	logic [LIDX_W-1:0]        lane_q;
	logic [EIDX_W-1:0]        emit_q;
	logic [6:0]               total_q;
	logic                     out_valid_q;
	out_item_t                out_q;
	logic                     slot_free;
	logic                     do_load;
	logic                     do_conv;
	logic                     do_fold;
	logic                     do_emit;
	logic                     emit_last;
	logic                     conv_done;
	logic                     fold_done;
	logic [6:0]               num;
	logic [6:0]               num_fixed;
	logic [DIG_W-1:0]         dadj [LANES];
	logic [DIG_W-1:0]         sadj [LANES];
	lane_vec_t                dstart;

	assign slot_free = ~out_valid_q | ~dig_stall;
	assign emit_last = (emit_q == EIDX_W'(NUM_OUT - 1));
	assign conv_done = (bit_q == BIT_W'(ACC_W - 1));
	assign fold_done = (lane_q == LIDX_W'(LANES - 1));

	// Sequencer: load a record, convert to decimal, fold snapshot sums, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		do_load  = 1'b0;
		do_conv  = 1'b0;
		do_fold  = 1'b0;
		do_emit  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_nonempty) begin
					do_load  = 1'b1;
					state_nx = BK_CONV;
				end
			end
			BK_CONV: begin
				do_conv = 1'b1;
				if (conv_done) begin
					state_nx = BK_FOLD;
				end
			end
			BK_FOLD: begin
				do_fold = 1'b1;
				if (fold_done) begin
					state_nx = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (slot_free) begin
					do_emit = 1'b1;
					if (emit_last) begin
						state_nx = BK_IDLE;
					end
				end
			end
			default: begin
				state_nx = BK_IDLE;
			end
		endcase
	end

	assign pop = do_load;

	// Per-lane digest value and one double-dabble step for each lane.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			dstart[k] = add_mod(head.acc[k], head.snap[k]);
			if (dstart[k] < MIN16) begin
				dstart[k] = dstart[k] + MIN16;
			end
			dadj[k] = bcd_adj(digits_q[(LANES-1-k)*DIG_W +: DIG_W]);
			sadj[k] = bcd_adj(DIG_W'(sbcd_q[k]));
		end
	end

	// Current two-digit number, with the snapshot total folded into the last one.
	always_comb begin
		num = pair_bin(digits_q[LANES*DIG_W-1 -: 8]);
		if (emit_last) begin
			num = add_mod100(num, total_q);
		end
		num_fixed = num;
		if (num == '0) begin
			num_fixed = 7'd1;
		end
		if (num > NUM_WRAP) begin
			num_fixed = num - NUM_WRAP;
		end
	end

	// Conversion datapath.
	always_ff @(posedge clk) begin
		if (do_load) begin
			dbin_q   <= dstart;
			sbin_q   <= head.snap;
			digits_q <= '0;
			for (int k = 0; k < LANES; k++) begin
				sbcd_q[k] <= '0;
			end
			total_q  <= '0;
		end
		if (do_conv) begin
			for (int k = 0; k < LANES; k++) begin
				digits_q[(LANES-1-k)*DIG_W +: DIG_W] <= {dadj[k][DIG_W-2:0], dbin_q[k][ACC_W-1]};
				dbin_q[k] <= dbin_q[k] << 1;
				sbcd_q[k] <= {sadj[k][6:0], sbin_q[k][ACC_W-1]};
				sbin_q[k] <= sbin_q[k] << 1;
			end
		end
		if (do_fold) begin
			total_q <= add_mod100(total_q, pair_bin(sbcd_q[lane_q]));
		end
		if (do_emit) begin
			digits_q <= digits_q << 8;
		end
	end

	// Step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			lane_q <= '0;
			emit_q <= '0;
		end else begin
			if (do_load) begin
				bit_q  <= '0;
				lane_q <= '0;
				emit_q <= '0;
			end
			if (do_conv) begin
				bit_q <= bit_q + 1'b1;
			end
			if (do_fold && !fold_done) begin
				lane_q <= lane_q + 1'b1;
			end
			if (do_emit) begin
				emit_q <= emit_q + 1'b1;
			end
		end
	end

	// Output register; it holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (!dig_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_q.digest_char <= num_fixed + CHAR_BIAS;
			out_q.last_char   <= emit_last;
		end
	end

	assign dig_valid = out_valid_q;
	assign dig_item  = out_q;

endmodule

### hw/rtl/decimal_multilane_text_hash_top.sv
// Top level of the decimal multilane text hash: register port, front, queue and back.
//
// Characters enter on the char channel (char_valid, char_stall, char_item), one
// item per cycle with no gaps needed while the queue is not full. The item
// marked last_input closes a message; 32 digest characters then leave on the dig
// channel (dig_valid, dig_stall, dig_item), the final one flagged by last_char.
// The front takes one character a cycle while the queue is not full; the lane
// update, a small constant multiply with modulus reduction, is combinational. A
// finished message waits in a two-entry queue. The back converts each lane to
// decimal one bit a cycle, folds the snapshot sums (one lane a cycle), then emits
// one character a cycle while the receiver does not stall. Characters of the next
// message are taken meanwhile until the queue fills.
// When the receiver stalls, the output register holds its item and the back waits.
// Reset seeds the lanes, clears the position counter, queue and output, and sets the
// snapshot interval (byte address 0) to 10000; no clearing pass is needed.
module decimal_multilane_text_hash_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dmth_pkg::ADDR_W-1:0] paddr,
	input  logic [dmth_pkg::DATA_W-1:0] pwdata,
	output logic [dmth_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        char_valid,
	output logic                        char_stall,
	input  dmth_pkg::in_item_t          char_item,
	output logic                        dig_valid,
	input  logic                        dig_stall,
	output dmth_pkg::out_item_t         dig_item
);
	import dmth_pkg::*;

	logic [IV_W-1:0] interval_q;
	logic            q_full;
	logic            q_nonempty;
	logic            push;
	logic            pop;
	rec_t            push_rec;
	rec_t            head;
	logic            reg_sel;

	// Register port: a single register, decoded at addresses 0 to 3 by the top address bit.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1] == REG_INTERVAL[ADDR_W-1]);
	assign prdata  = reg_sel ? DATA_W'(interval_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IV_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			interval_q <= pwdata[IV_W-1:0];
		end
	end

	dmth_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.interval   (interval_q),
		.q_full     (q_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	dmth_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.nonempty (q_nonempty),
		.pop      (pop),
		.head     (head)
	);

	dmth_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig_item   (dig_item)
	);

endmodule

### tb/sv/tb_decimal_multilane_text_hash_top.sv
// Self-checking testbench for the decimal multilane text hash top level.
`timescale 1ns / 1ps

import dmth_pkg::*;

// Predicts the digest of each message and checks the digest characters in order.
class digest_board;
	localparam longint unsigned DEC16   = 64'd10000000000000000;
	localparam longint unsigned DEC15   = 64'd1000000000000000;
	localparam longint unsigned SEED_NR = 64'd5555555555555555;
	localparam int              POS_TOP = 131071;

	longint unsigned lane_acc[LANES];
	longint unsigned lane_snap[LANES];
	int              position;
	int              interval;
	out_item_t       digest_due[$];
	int              mismatches;
	int              digests_seen;
	int              messages;

	function new();
		interval   = 10000;
		mismatches = 0;
		digests_seen = 0;
		messages   = 0;
		restart();
	endfunction

	function void restart();
		for (int k = 0; k < LANES; k++) begin
			lane_acc[k]  = SEED_NR;
			lane_snap[k] = SEED_NR;
		end
		position = 0;
	endfunction

	task report(string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Folds one accepted character into the lanes; a last character queues its digest.
	function void take_char(in_item_t it);
		longint unsigned shift;
		longint unsigned d;
		longint unsigned divisor;
		int              nums[NUM_OUT];
		int              snap_total;
		bit              at_snap;
		out_item_t       o;
		shift = (longint'(it.character) + DEC16 - 32) % DEC16;
		at_snap = 1'b0;
		for (int m = 1; m <= 4; m++) begin
			if (position == m * interval) at_snap = 1'b1;
		end
		for (int k = 0; k < LANES; k++) begin
			lane_acc[k] = (((lane_acc[k] + shift) % DEC16) * longint'(k + 2)) % DEC16;
			if (at_snap) lane_snap[k] = (lane_snap[k] + lane_acc[k]) % DEC16;
		end
		if (position < POS_TOP) position++;
		if (!it.last_input) return;

		snap_total = 0;
		for (int k = 0; k < LANES; k++) begin
			d = (lane_acc[k] + lane_snap[k]) % DEC16;
			if (d < DEC15) d += DEC15;
			divisor = 64'd100000000000000;
			for (int j = 0; j < 8; j++) begin
				nums[k * 8 + j] = int'((d / divisor) % 100);
				divisor /= 100;
			end
			snap_total += int'(lane_snap[k] % 100);
		end
		nums[NUM_OUT-1] = (nums[NUM_OUT-1] + snap_total) % 100;
		for (int j = 0; j < NUM_OUT; j++) begin
			if (nums[j] == 0) nums[j] = 1;
			if (nums[j] > 94) nums[j] -= 94;
			o.digest_char = 7'(nums[j] + 32);
			o.last_char   = (j == NUM_OUT - 1);
			digest_due.push_back(o);
		end
		messages++;
		restart();
	endfunction

	// Compares one accepted digest character with the oldest prediction.
	task check_digest(out_item_t got);
		out_item_t want;
		digests_seen++;
		if (digest_due.size() == 0) begin
			report($sformatf("unexpected digest char %0d", got.digest_char));
			return;
		end
		want = digest_due.pop_front();
		if (got.digest_char !== want.digest_char)
			report($sformatf("digest_char %0d, predicted %0d",
				got.digest_char, want.digest_char));
		if (got.last_char !== want.last_char)
			report($sformatf("last_char %0b, predicted %0b", got.last_char, want.last_char));
	endtask
endclass

module tb_decimal_multilane_text_hash_top;
	localparam int CYCLE_LIMIT = 250000;
	localparam int DRAIN       = 120;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                char_valid;
	logic                char_stall;
	in_item_t            char_item;
	logic                dig_valid;
	logic                dig_stall;
	out_item_t           dig_item;

	digest_board board = new();
	bit                  calm;
	int                  cycles;
	int                  stall_left;
	int                  chars_sent;

	decimal_multilane_text_hash_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
		.dig_valid(dig_valid), .dig_stall(dig_stall), .dig_item(dig_item)
	);

	always #2 clk = ~clk;

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 18);
	endfunction

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Digest side: check accepted items and stall a random number of cycles per item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (dig_valid && !dig_stall) begin
				board.check_digest(dig_item);
				stall_left = draw_gap();
				dig_stall <= (stall_left > 0);
			end else if (stall_left > 0) begin
				stall_left--;
				dig_stall <= (stall_left > 0);
			end else begin
				dig_stall <= 1'b0;
			end
		end
	end

	// Register write with setup and access cycles, followed by a read-back.
	task automatic write_interval(int value);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= REG_INTERVAL; pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[IV_W-1:0] !== IV_W'(value))
			board.report($sformatf("interval reads %0d, written %0d", prdata, value));
		psel <= 1'b0; penable <= 1'b0;
		board.interval = value & 16'h7FFF;
	endtask

	// Sends one character, waiting a drawn gap first and then for acceptance.
	task automatic send_char(logic [6:0] ch, logic last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item.character  <= ch;
		char_item.last_input <= last;
		do @(posedge clk); while (char_stall);
		board.take_char('{character: ch, last_input: last});
		chars_sent++;
	endtask

	// Waits until every predicted digest has left, then lets the back settle.
	task automatic wait_drained();
		char_valid <= 1'b0;
		while (board.digest_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// A message of random length and content; most characters printable.
	task automatic random_message(int max_len);
		int len;
		logic [6:0] ch;
		len = $urandom_range(1, max_len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) ch = 7'($urandom_range(0, 127));
			else ch = 7'($urandom_range(32, 126));
			send_char(ch, i == len - 1);
		end
	endtask

	initial begin
		int intervals[6] = '{2, 3, 0, 5, 1, 7};
		clk = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		paddr <= '0; pwdata <= '0;
		char_valid <= 1'b0; char_item <= '0;
		dig_stall <= 1'b0;
		cycles <= 0;
		stall_left = 0;
		chars_sent = 0;
		calm = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset interval, extreme and out-of-range characters.
		send_char(7'd32, 1'b1);
		send_char(7'd126, 1'b0);
		send_char(7'd0, 1'b0);
		send_char(7'd31, 1'b0);
		send_char(7'd127, 1'b0);
		send_char(7'd32, 1'b1);
		send_char(7'd0, 1'b1);
		send_char(7'd127, 1'b1);
		wait_drained();

		// Directed: zero interval takes a single snapshot at position zero.
		write_interval(0);
		send_char(7'd65, 1'b1);
		send_char(7'd90, 1'b0);
		send_char(7'd33, 1'b1);
		wait_drained();

		// Directed: interval one, snapshots on positions one to four.
		write_interval(1);
		for (int i = 0; i < 7; i++) send_char(7'(33 + i * 13), i == 6);
		wait_drained();

		// Random messages over several intervals, with calm stretches.
		foreach (intervals[p]) begin
			write_interval(intervals[p]);
			calm = (p % 3 == 1);
			for (int m = 0; m < 8; m++) random_message(($urandom_range(0, 5) == 0) ? 30 : 10);
			wait_drained();
		end
		calm = 1'b0;
		write_interval(10000);
		for (int m = 0; m < 4; m++) random_message(12);
		wait_drained();

		// The widest interval, whose snapshot positions short messages never reach.
		write_interval(32767);
		random_message(10);
		wait_drained();

		$display("Sent %0d characters in %0d messages; checked %0d digest characters.",
			chars_sent, board.messages, board.digests_seen);
		$display("Intervals 0, 1, 2, 3, 5, 7, 10000 and 32767 used, under random stalls.");
		if (board.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
